// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the parser core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/csvp_pkg.sv =====
// Types and constants of the CSV field parser.
`timescale 1ns / 1ps
package csvp_pkg;

  typedef enum logic [3:0] {
    MODE_NORMAL  = 4'b0001,
    MODE_QUOTED  = 4'b0010,
    MODE_ESCAPED = 4'b0100,
    MODE_COMMENT = 4'b1000
  } mode_t;

  localparam logic [1:0] KIND_CHAR = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_EOI  = 2'd2;

  localparam logic [7:0] REG_DELIMITER = 8'd0;
  localparam logic [7:0] REG_FIELDS    = 8'd1;
  localparam logic [7:0] REG_CAPACITY  = 8'd2;

  localparam logic [7:0]  CH_QUOTE = 8'h22;
  localparam logic [7:0]  CH_HASH  = 8'h23;
  localparam logic [7:0]  CH_CR    = 8'h0D;
  localparam logic [7:0]  CH_LF    = 8'h0A;
  localparam logic [7:0]  CH_BSL   = 8'h5C;
  localparam logic [7:0]  CH_SPACE = 8'h20;
  localparam logic [7:0]  CH_COMMA = 8'h2C;

  localparam logic [15:0] CAPACITY_RST = 16'd1000;
  localparam logic [7:0]  FIELDS_RST   = 8'd1;

  typedef struct packed {
    logic [7:0]  delimiter;
    logic [7:0]  fields_per_record;
    logic [15:0] field_capacity;
  } cfg_t;

  typedef struct packed {
    mode_t       mode;
    logic [7:0]  field_index;
    logic [15:0] char_count;
    logic        skip_spaces;
    logic [31:0] records_done;
    logic        field_dropped;
    logic        finished;
  } state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  out_char;
    logic [7:0]  field_number;
    logic        record_end;
    logic [31:0] record_total;
    logic        overflowed;
  } res_t;

endpackage

// ===== hw/rtl/csvp_in_if.sv =====
// Input byte channel.
`timescale 1ns / 1ps
interface csvp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

// ===== hw/rtl/csvp_out_if.sv =====
// Result channel.
`timescale 1ns / 1ps
interface csvp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  out_kind;
  logic [7:0]  out_char;
  logic [7:0]  field_number;
  logic        record_end;
  logic [31:0] record_total;
  logic        overflowed;

  modport source (output valid, output out_kind, output out_char, output field_number,
                  output record_end, output record_total, output overflowed, input ready);
  modport sink   (input valid, input out_kind, input out_char, input field_number,
                  input record_end, input record_total, input overflowed, output ready);
endinterface

// ===== hw/rtl/csvp_cfg_if.sv =====
// Configuration write channel.
`timescale 1ns / 1ps
interface csvp_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  addr;
  logic [15:0] data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

// ===== hw/rtl/csvp_step.sv =====
// Next-state and result logic for one input byte.
`timescale 1ns / 1ps
module csvp_step (
  input  csvp_pkg::state_t cur,
  input  csvp_pkg::cfg_t   cfg,
  input  logic [7:0]       in_byte,
  input  logic             end_of_input,
  output csvp_pkg::state_t nxt,
  output logic             res_valid,
  output csvp_pkg::res_t   res
);
  import csvp_pkg::*;

  logic       do_keep;
  logic [7:0] keep_ch;
  logic       do_end;
  logic       rec_end;

  assign rec_end = ({1'b0, cur.field_index} + 9'd1) >= {1'b0, cfg.fields_per_record};

  always_comb begin
    nxt       = cur;
    res_valid = 1'b0;
    res       = '0;
    do_keep   = 1'b0;
    keep_ch   = in_byte;
    do_end    = 1'b0;

    if (!cur.finished) begin
      if (end_of_input) begin
        res_valid          = 1'b1;
        res.kind           = KIND_EOI;
        res.field_number   = cur.field_index;
        res.record_total   = cur.records_done;
        nxt.finished       = 1'b1;
      end else if (!(cur.skip_spaces && in_byte == CH_SPACE)) begin
        nxt.skip_spaces = 1'b0;
        unique case (cur.mode)
          MODE_NORMAL: begin
            priority if (in_byte == cfg.delimiter) do_end = 1'b1;
            else if (in_byte == CH_QUOTE) nxt.mode = MODE_QUOTED;
            else if (in_byte == CH_CR) ;
            else if (in_byte == CH_LF) do_end = (cur.field_index != 8'd0);
            else if (in_byte == CH_HASH && cur.field_index == 8'd0) nxt.mode = MODE_COMMENT;
            else do_keep = 1'b1;
          end
          MODE_QUOTED: begin
            priority if (in_byte == CH_QUOTE) nxt.mode = MODE_NORMAL;
            else if (in_byte == CH_CR) ;
            else if (in_byte == CH_LF) begin
              do_keep = 1'b1;
              keep_ch = CH_SPACE;
            end
            else if (in_byte == CH_BSL) nxt.mode = MODE_ESCAPED;
            else do_keep = 1'b1;
          end
          MODE_ESCAPED: begin
            priority if (in_byte == CH_QUOTE) begin
              nxt.mode = MODE_QUOTED;
              do_keep  = 1'b1;
              keep_ch  = CH_QUOTE;
            end
            else if (in_byte == CH_CR || in_byte == CH_LF) ;
            else nxt.mode = MODE_QUOTED;
          end
          MODE_COMMENT: begin
            if (in_byte == CH_LF) nxt.mode = MODE_NORMAL;
          end
          default: nxt.mode = MODE_NORMAL;
        endcase
      end
    end

    if (do_keep) begin
      if (cur.char_count < cfg.field_capacity) begin
        nxt.char_count = cur.char_count + 16'd1;
        res_valid      = 1'b1;
        res.kind       = KIND_CHAR;
        res.out_char   = keep_ch;
        res.field_number = cur.field_index;
        res.record_total = cur.records_done;
      end else begin
        nxt.field_dropped = 1'b1;
      end
    end

    if (do_end) begin
      res_valid        = 1'b1;
      res.kind         = KIND_END;
      res.field_number = cur.field_index;
      res.record_end   = rec_end;
      res.overflowed   = cur.field_dropped;
      if (rec_end) begin
        if (cur.records_done != 32'hFFFF_FFFF) nxt.records_done = cur.records_done + 32'd1;
        nxt.field_index = 8'd0;
      end else begin
        nxt.field_index = cur.field_index + 8'd1;
      end
      res.record_total  = nxt.records_done;
      nxt.char_count    = 16'd0;
      nxt.field_dropped = 1'b0;
      nxt.mode          = MODE_NORMAL;
      nxt.skip_spaces   = (cfg.delimiter == CH_SPACE);
    end
  end
endmodule

// ===== hw/rtl/csv_field_parser_core.sv =====
// Top level of the CSV field parser: state, configuration and output buffer.
// A result is registered into the output head, or into the skid entry while the head stalls.
// Throughput: one byte per cycle while input is ready; a two-entry output buffer lets one
//   result park during an output stall, and input stops only when both entries are full.
// Reset (synchronous, rst_n low): parser state cleared, registers back to
//   delimiter ',', one field per record, capacity 1000; output buffer emptied.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module csv_field_parser_core (
  input logic clk,
  input logic rst_n,
  csvp_in_if.sink    in_ch,
  csvp_out_if.source out_ch,
  csvp_cfg_if.sink   cfg_ch
);
  import csvp_pkg::*;

  // configuration registers
  cfg_t   cfg_r;
  // parser state, updated at every input transfer
  state_t state_r;
  state_t state_nxt;

  // output buffer: head entry drives the port, skid entry catches a stall
  res_t   out_res_r;
  res_t   skid_res_r;
  logic   out_valid_r;
  logic   skid_valid_r;

  logic   step_valid;
  res_t   step_res;
  logic   in_fire;
  logic   out_fire;
  logic   cfg_fire;

  csvp_step u_step (
    .cur          (state_r),
    .cfg          (cfg_r),
    .in_byte      (in_ch.in_byte),
    .end_of_input (in_ch.end_of_input),
    .nxt          (state_nxt),
    .res_valid    (step_valid),
    .res          (step_res)
  );

  // input stops only while the skid entry is occupied
  assign in_ch.ready  = !skid_valid_r;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_fire     = out_valid_r && out_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign cfg_fire     = cfg_ch.valid && cfg_ch.ready;

  // configuration writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.delimiter         <= CH_COMMA;
      cfg_r.fields_per_record <= FIELDS_RST;
      cfg_r.field_capacity    <= CAPACITY_RST;
    end else if (cfg_fire) begin
      unique case (cfg_ch.addr)
        REG_DELIMITER: cfg_r.delimiter         <= cfg_ch.data[7:0];
        REG_FIELDS:    cfg_r.fields_per_record <= cfg_ch.data[7:0];
        REG_CAPACITY:  cfg_r.field_capacity    <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.mode          <= MODE_NORMAL;
      state_r.field_index   <= 8'd0;
      state_r.char_count    <= 16'd0;
      state_r.skip_spaces   <= 1'b0;
      state_r.records_done  <= 32'd0;
      state_r.field_dropped <= 1'b0;
      state_r.finished      <= 1'b0;
    end else if (in_fire) begin
      state_r <= state_nxt;
    end
  end

  // output buffer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_fire) begin
      // head is free this cycle: refill from skid first, else from the step
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= in_fire && step_valid;
      end
    end else if (in_fire && step_valid) begin
      // head stalled: park the new result
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_fire) begin
      if (skid_valid_r) out_res_r <= skid_res_r;
      else if (in_fire && step_valid) out_res_r <= step_res;
    end else if (in_fire && step_valid) begin
      skid_res_r <= step_res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.out_kind     = out_res_r.kind;
  assign out_ch.out_char     = out_res_r.out_char;
  assign out_ch.field_number = out_res_r.field_number;
  assign out_ch.record_end   = out_res_r.record_end;
  assign out_ch.record_total = out_res_r.record_total;
  assign out_ch.overflowed   = out_res_r.overflowed;

  // skid entry is never filled while the head is empty
  `ASSERT_IMPL(a_skid_has_head, clk, rst_n, skid_valid_r, out_valid_r)
  // a stalled result stays put
  `ASSERT_NEXT(a_head_holds, clk, rst_n, out_valid_r && !out_ch.ready,
               out_valid_r && $stable(out_res_r))
  // end of input is sticky until reset
  `ASSERT_NEXT(a_finished_sticks, clk, rst_n, state_r.finished, state_r.finished)
  // record count never goes back
  `ASSERT_NEXT(a_records_monotonic, clk, rst_n, 1'b1,
               state_r.records_done >= $past(state_r.records_done))
endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the CSV field parser core.
`timescale 1ns / 1ps
module tb;
  import csvp_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 400000;  // generous watchdog
  localparam int unsigned DRAIN_LIMIT   = 20000;   // bound on waiting for results
  localparam int unsigned SETTLE_CYCLES = 4;       // wait after the last pending token arrives
  localparam int unsigned PHASE_BYTES   = 250;     // random bytes per parser setting
  localparam int unsigned MAX_PRINTS    = 20;
  localparam logic [7:0]  REG_SPARE     = 8'd3;    // index with no register behind it

  // Tracks parser state and the tokens (chars, field ends, end marks) it must emit.
  class field_tracker;
    logic [7:0]  sep;
    logic [7:0]  rec_fields;
    logic [15:0] cap_limit;
    mode_t       mode;
    logic [7:0]  fld;
    logic [15:0] kept;
    logic        skip_sp;
    logic [31:0] records;
    logic        dropped;
    logic        halted;
    res_t        tokens_due[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned field_ends;
    int unsigned rec_ends;
    int unsigned ovf_ends;
    int unsigned eoi_marks;

    function new();
      sep        = CH_COMMA;
      rec_fields = FIELDS_RST;
      cap_limit  = CAPACITY_RST;
      mode       = MODE_NORMAL;
      fld        = '0;
      kept       = '0;
      skip_sp    = 1'b0;
      records    = '0;
      dropped    = 1'b0;
      halted     = 1'b0;
      errors     = 0;
      checked    = 0;
      field_ends = 0;
      rec_ends   = 0;
      ovf_ends   = 0;
      eoi_marks  = 0;
    endfunction

    function void apply_reg(logic [7:0] idx, logic [15:0] val);
      case (idx)
        REG_DELIMITER: sep = val[7:0];
        REG_FIELDS:    rec_fields = val[7:0];
        REG_CAPACITY:  cap_limit = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return tokens_due.size();
    endfunction

    function void queue_token(logic [1:0] kind, logic [7:0] ch, logic [7:0] fnum,
                              logic rend, logic ovf);
      res_t t;
      t.kind         = kind;
      t.out_char     = ch;
      t.field_number = fnum;
      t.record_end   = rend;
      t.record_total = records;
      t.overflowed   = ovf;
      tokens_due.push_back(t);
    endfunction

    function void keep_char(logic [7:0] ch);
      if (kept < cap_limit) begin
        kept++;
        queue_token(KIND_CHAR, ch, fld, 1'b0, 1'b0);
      end else begin
        dropped = 1'b1;
      end
    endfunction

    function void close_field();
      logic       rend;
      logic       ovf;
      logic [7:0] fnum;
      // zero fields per record behaves as one
      rend = (int'(fld) + 1 >= int'(rec_fields));
      ovf  = dropped;
      fnum = fld;
      if (rend) begin
        if (records != '1) records++;
        fld = '0;
      end else begin
        fld++;
      end
      queue_token(KIND_END, 8'd0, fnum, rend, ovf);
      kept    = '0;
      dropped = 1'b0;
      mode    = MODE_NORMAL;
      skip_sp = (sep == CH_SPACE);
    endfunction

    // Called for every accepted input transfer.
    function void note_byte(logic [7:0] b, logic eoi);
      if (halted) return;
      if (eoi) begin
        queue_token(KIND_EOI, 8'd0, fld, 1'b0, 1'b0);
        halted = 1'b1;
        return;
      end
      if (skip_sp) begin
        if (b == CH_SPACE) return;
        skip_sp = 1'b0;
      end
      case (mode)
        MODE_NORMAL: begin
          // delimiter wins over every other rule
          if (b == sep) close_field();
          else if (b == CH_QUOTE) mode = MODE_QUOTED;
          else if (b == CH_CR) ;
          else if (b == CH_LF) begin
            if (fld != 0) close_field();
          end else if (b == CH_HASH && fld == 0) mode = MODE_COMMENT;
          else keep_char(b);
        end
        MODE_QUOTED: begin
          if (b == CH_QUOTE) mode = MODE_NORMAL;
          else if (b == CH_CR) ;
          else if (b == CH_LF) keep_char(CH_SPACE);
          else if (b == CH_BSL) mode = MODE_ESCAPED;
          else keep_char(b);
        end
        MODE_ESCAPED: begin
          if (b == CH_QUOTE) begin
            mode = MODE_QUOTED;
            keep_char(CH_QUOTE);
          end else if (b != CH_CR && b != CH_LF) begin
            mode = MODE_QUOTED;
          end
        end
        default: begin
          if (b == CH_LF) mode = MODE_NORMAL;
        end
      endcase
    endfunction

    task report_diff(string msg);
      errors++;
      if (errors <= MAX_PRINTS) $display("ERROR: %s", msg);
    endtask

    task check_token(res_t got);
      res_t want;
      if (got.kind == KIND_END) begin
        field_ends++;
        rec_ends += got.record_end;
        ovf_ends += got.overflowed;
      end
      if (got.kind == KIND_EOI) eoi_marks++;
      if (tokens_due.size() == 0) begin
        report_diff($sformatf("unexpected token kind %0d char %02h field %0d",
                              got.kind, got.out_char, got.field_number));
        return;
      end
      want = tokens_due.pop_front();
      checked++;
      if (got.kind !== want.kind || got.out_char !== want.out_char ||
          got.field_number !== want.field_number || got.record_end !== want.record_end ||
          got.record_total !== want.record_total || got.overflowed !== want.overflowed)
        report_diff($sformatf(
          "token %0d got k%0d c%02h f%0d re%0b t%0d o%0b want k%0d c%02h f%0d re%0b t%0d o%0b",
          checked, got.kind, got.out_char, got.field_number, got.record_end,
          got.record_total, got.overflowed, want.kind, want.out_char, want.field_number,
          want.record_end, want.record_total, want.overflowed));
    endtask

    task flush_missing();
      report_diff($sformatf("%0d tokens never arrived", tokens_due.size()));
      tokens_due.delete();
    endtask
  endclass

  logic clk;
  logic rst_n;

  csvp_in_if  in_ch();
  csvp_out_if out_ch();
  csvp_cfg_if cfg_ch();

  csv_field_parser_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  field_tracker tracker;
  logic [7:0]   chunk[$];       // bytes of the text piece being sent
  int unsigned  bytes_sent = 0;
  int unsigned  settings = 0;
  int unsigned  cycle_count = 0;
  int           send_idle_pct = 29;
  int           recv_idle_pct = 60;
  int           hold_cycles = 0;  // long receiver hold-off, counted down by the receiver

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Watchdog: a hung handshake or lost token ends here.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("csv_field_parser_core: mismatch");
    $finish;
  end

  // Receiver: random ready at the falling edge, or a long hold when asked.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Monitor: every result transfer is checked against the oldest pending token.
  always @(posedge clk) begin : result_mon
    res_t seen;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      seen.kind         = out_ch.out_kind;
      seen.out_char     = out_ch.out_char;
      seen.field_number = out_ch.field_number;
      seen.record_end   = out_ch.record_end;
      seen.record_total = out_ch.record_total;
      seen.overflowed   = out_ch.overflowed;
      tracker.check_token(seen);
    end
  end

  // One byte transfer; random gaps before it, held until the block takes it.
  task automatic push_item(input logic [7:0] b, input logic eoi);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_ch.valid   <= 1'b0;
      in_ch.in_byte <= 8'($urandom);
    end
    @(negedge clk);
    in_ch.valid        <= 1'b1;
    in_ch.in_byte      <= b;
    in_ch.end_of_input <= eoi;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    tracker.note_byte(b, eoi);
    bytes_sent++;
  endtask

  task automatic send_chunk();
    foreach (chunk[i]) push_item(chunk[i], 1'b0);
    chunk.delete();
  endtask

  task automatic add_str(input string s);
    foreach (s[i]) chunk.push_back(s[i]);
  endtask

  // Stop sending, wait for every pending token, then let the pipe empty.
  task automatic settle();
    int unsigned waited;
    waited = 0;
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (tracker.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (tracker.pending() != 0) tracker.flush_missing();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.addr  <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    tracker.apply_reg(idx, val);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Upper data bits of the 8-bit registers carry junk; only the low byte counts.
  task automatic configure(input logic [7:0] delim, input logic [7:0] fpr,
                           input logic [15:0] cap);
    settle();
    write_reg(REG_DELIMITER, {8'($urandom), delim});
    write_reg(REG_FIELDS, {8'($urandom), fpr});
    write_reg(REG_CAPACITY, cap);
    settings++;
  endtask

  function automatic logic [7:0] text_char();
    int r;
    r = $urandom_range(9);
    if (r < 6) return 8'h61 + 8'($urandom_range(25));
    if (r < 8) return 8'h30 + 8'($urandom_range(9));
    return 8'($urandom);
  endfunction

  // Quoted field body: folded newlines, escapes good and bad, embedded delimiters.
  task automatic add_quoted(input int len, input logic [7:0] delim, input bit close);
    chunk.push_back(CH_QUOTE);
    repeat (len) begin
      case ($urandom_range(9))
        0: chunk.push_back(CH_LF);
        1: chunk.push_back(CH_CR);
        2: begin chunk.push_back(CH_BSL); chunk.push_back(CH_QUOTE); end
        3: begin chunk.push_back(CH_BSL); chunk.push_back(text_char()); end
        4: begin chunk.push_back(CH_BSL); chunk.push_back(CH_CR); end
        5: chunk.push_back(delim);
        default: chunk.push_back(text_char());
      endcase
    end
    if (close) chunk.push_back(CH_QUOTE);
  endtask

  // Mostly well-formed records; some comments, blank lines, noise and broken quotes.
  task automatic build_chunk(input logic [7:0] delim, input logic [7:0] fpr,
                             input logic [15:0] cap);
    int r;
    int nf;
    int len;
    r = $urandom_range(99);
    if (r < 8) begin
      chunk.push_back(CH_HASH);
      repeat ($urandom_range(0, 6)) chunk.push_back(text_char());
      chunk.push_back(CH_LF);
    end else if (r < 12) begin
      if ($urandom_range(1)) chunk.push_back(CH_CR);
      chunk.push_back(CH_LF);
    end else if (r < 22) begin
      repeat ($urandom_range(1, 6)) chunk.push_back(8'($urandom));
    end else begin
      if (fpr <= 1) nf = $urandom_range(1, 4);
      else if (fpr > 8) nf = $urandom_range(1, 8);
      else nf = fpr;
      if ($urandom_range(9) == 0) nf = nf + 1;
      for (int f = 0; f < nf; f++) begin
        if (cap <= 8) len = $urandom_range(0, cap + 3);
        else if ($urandom_range(19) == 0) len = $urandom_range(0, 40);
        else len = $urandom_range(0, 8);
        if ($urandom_range(2) == 0) add_quoted(len, delim, ($urandom_range(9) != 0));
        else repeat (len) chunk.push_back(text_char());
        if (f < nf - 1) begin
          chunk.push_back(delim);
          if (delim == CH_SPACE) repeat ($urandom_range(0, 3)) chunk.push_back(CH_SPACE);
        end
      end
      if ($urandom_range(1)) chunk.push_back(CH_CR);
      chunk.push_back(CH_LF);
    end
  endtask

  task automatic run_phase(input logic [7:0] delim, input logic [7:0] fpr,
                           input logic [15:0] cap, input int hold);
    int unsigned start;
    configure(delim, fpr, cap);
    if (hold > 0) hold_cycles = hold;
    start = bytes_sent;
    while (bytes_sent - start < PHASE_BYTES) begin
      build_chunk(delim, fpr, cap);
      send_chunk();
    end
  endtask

  initial begin
    in_ch.valid        = 1'b0;
    in_ch.in_byte      = 8'd0;
    in_ch.end_of_input = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.addr        = 8'd0;
    cfg_ch.data        = 16'd0;
    rst_n              = 1'b0;
    tracker            = new();
    repeat (11) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Directed: comment and blank line in field 0, quoted newline, good and bad
    // escapes, capacity overflow, byte extremes.
    write_reg(REG_SPARE, 16'hFFFF);
    configure(CH_COMMA, 8'd3, 16'd3);
    add_str("\n#x\n");
    add_str("a\"\n\\\"\\");
    chunk.push_back(CH_CR);
    add_str("x\",12");
    chunk.push_back(8'hFF);
    chunk.push_back(8'h00);
    chunk.push_back(CH_LF);
    send_chunk();
    // Space delimiter with space runs, zero fields per record, zero capacity.
    configure(CH_SPACE, 8'd0, 16'd0);
    add_str(" a  b");
    send_chunk();
    // Quote as delimiter takes precedence; hash outside field 0 is text.
    configure(CH_QUOTE, 8'd2, 16'hFFFF);
    add_str("x\"#\"");
    send_chunk();

    // Random part: sender idles less than receiver.
    run_phase(CH_COMMA, 8'd3, 16'd6, 0);
    run_phase(CH_SPACE, 8'd2, 16'hFFFF, 0);
    // Sender idles more than receiver.
    send_idle_pct = 60;
    recv_idle_pct = 29;
    run_phase(8'hFF, 8'd255, 16'd1, 0);
    run_phase(8'h00, 8'd1, CAPACITY_RST, 0);
    // No idling; a long receiver hold-off fills the output buffer first.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(8'h3B, 8'd4, 16'd3, 80);
    run_phase(CH_COMMA, 8'd2, 16'd8, 0);

    // End of input, then bytes the finished block must ignore.
    push_item(8'($urandom), 1'b1);
    repeat (6) push_item(8'($urandom), 1'($urandom));
    settle();

    $display("Sent %0d bytes over %0d parser settings; %0d tokens checked.",
             bytes_sent, settings, tracker.checked);
    $display("Saw %0d field ends (%0d closing records, %0d overflowed), %0d end marks.",
             tracker.field_ends, tracker.rec_ends, tracker.ovf_ends, tracker.eoi_marks);
    if (tracker.errors == 0) begin
      $display("csv_field_parser_core: match");
    end else begin
      $display("csv_field_parser_core: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/csvp_pkg.sv
hw/rtl/csvp_in_if.sv
hw/rtl/csvp_out_if.sv
hw/rtl/csvp_cfg_if.sv
hw/rtl/csvp_step.sv
hw/rtl/csv_field_parser_core.sv
test/tb.sv
